FILE: rtl/fba_pkg.sv
package fba_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned BSIZE_W   = 17;
   localparam int unsigned CNT_W     = 11;
   localparam int unsigned PROD_W    = BSIZE_W + CNT_W;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BSIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP   = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NULL     = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd4096;
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd64;
   localparam int unsigned        CAP_RESET   = 1024;

   typedef struct packed {
      logic pop;
      logic push;
      logic refill;
   } stk_cmd_type;

endpackage

FILE: rtl/fixed_block_allocator.sv
// Fixed-size block pool allocator. Each req beat either allocates a block
// (req_mode 0) or frees the block at req_address (req_mode 1), and yields
// exactly one rsp beat with a status, the allocated address and the usage
// counters. Free block indices sit on a LIFO stack in a single-port-style
// memory of MAX_BLOCKS entries (capped at 2047); a low-water mark stands in
// for the initial fill, so there is no clearing pass after reset or after a
// capacity write. Items are handled one at a time: an allocate goes
// through stack read, multiply, add and output load; a free of a
// non-null address inside the pool goes through the 11-step restoring
// divider that turns the offset into a block index, and one that falls
// outside the pool goes from the range check to output load. A null
// free or an allocate from an empty pool goes straight to output load.
// A result may wait in the output register while the next item is
// accepted. Write the csr registers only while the block is idle.
module fixed_block_allocator
   import fba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wr_data,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [ADDR_W-1:0]    req_address,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [ADDR_W-1:0]    rsp_block_address,
   output logic [CNT_W-1:0]     rsp_blocks_in_use,
   output logic [CNT_W-1:0]     rsp_highest_in_use,
   output logic [ADDR_W-1:0]    rsp_total_allocated,
   output logic [ADDR_W-1:0]    rsp_total_freed
);

   localparam int unsigned CAP_MAX   = (1 << CNT_W) - 1;
   localparam int unsigned DEPTH     = (MAX_BLOCKS < CAP_MAX) ? MAX_BLOCKS : CAP_MAX;
   localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned RESET_CAP = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
   localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_AMUL,
      S_AADD,
      S_FCHK,
      S_FDIV,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [BSIZE_W-1:0] bs_ff, bs_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   in_use_ff, in_use_in;
   logic [CNT_W-1:0]   peak_ff, peak_in;
   logic [ADDR_W-1:0]  alloc_ff, alloc_in;
   logic [ADDR_W-1:0]  freed_ff, freed_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [CNT_W-1:0]   rsp_in_use_ff, rsp_in_use_in;
   logic [CNT_W-1:0]   rsp_peak_ff, rsp_peak_in;
   logic [ADDR_W-1:0]  rsp_alloc_ff, rsp_alloc_in;
   logic [ADDR_W-1:0]  rsp_freed_ff, rsp_freed_in;

   stk_cmd_type        stk_cmd;
   logic [IDX_W-1:0]   pop_data;
   logic [CNT_W-1:0]   free_count;
   logic [CNT_W-1:0]   cap_wr;
   logic [BSIZE_W-1:0] bs_wr;
   logic [CNT_W-1:0]   mul_a;
   logic [CNT_W-1:0]   in_use_inc;
   logic               accept;
   logic               div_start;
   logic               div_done;
   logic [CNT_W-1:0]   div_quo;
   logic               div_rem_zero;
   logic               csr_cap_wr;

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign cap_wr     = (csr_wr_data[CNT_W-1:0] > CAP_LIM) ? CAP_LIM : csr_wr_data[CNT_W-1:0];
   assign bs_wr      = (csr_wr_data[BSIZE_W-1:0] == '0) ? BSIZE_W'(1)
                                                        : csr_wr_data[BSIZE_W-1:0];
   assign csr_cap_wr = csr_wr_en && (csr_index == CSR_CAP);
   assign in_use_inc = in_use_ff + CNT_W'(1);
   assign div_start  = (state_ff == S_FCHK) && (offset_ff < ADDR_W'(prod_ff));

   // One shared multiplier: index times block size on allocate, capacity
   // times block size (pool span) on free.
   assign mul_a   = (state_ff == S_AMUL) ? CNT_W'(pop_data) : cap_ff;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(bs_ff);

   always_comb begin
      stk_cmd.pop    = accept && !req_mode && (free_count != '0);
      stk_cmd.push   = (state_ff == S_FDIV) && div_done && div_rem_zero
                       && (free_count < cap_ff);
      stk_cmd.refill = csr_cap_wr;
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      bs_in         = bs_ff;
      cap_in        = cap_ff;
      in_use_in     = in_use_ff;
      peak_in       = peak_ff;
      alloc_in      = alloc_ff;
      freed_in      = freed_ff;
      offset_in     = offset_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_in_use_in = rsp_in_use_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_freed_in  = rsp_freed_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE:  base_in = csr_wr_data;
            CSR_BSIZE: bs_in   = bs_wr;
            CSR_CAP: begin
               cap_in    = cap_wr;
               in_use_in = '0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_addr_in = '0;
               offset_in   = req_address - base_ff;
               if (!req_mode) begin
                  if (free_count == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_AMUL;
                  end
               end else if (req_address == '0) begin
                  res_status_in = ST_NULL;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_FCHK;
               end
            end
         end
         S_AMUL: state_in = S_AADD;
         S_AADD: begin
            res_status_in = ST_OK;
            res_addr_in   = base_ff + ADDR_W'(prod_ff);
            alloc_in      = alloc_ff + ADDR_W'(1);
            in_use_in     = in_use_inc;
            if (in_use_inc > peak_ff) begin
               peak_in = in_use_inc;
            end
            state_in = S_OUT;
         end
         S_FCHK: begin
            if (div_start) begin
               state_in = S_FDIV;
            end else begin
               res_status_in = ST_INVALID;
               state_in      = S_OUT;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               if (!div_rem_zero) begin
                  res_status_in = ST_INVALID;
               end else if (free_count >= cap_ff) begin
                  res_status_in = ST_OVERFLOW;
               end else begin
                  res_status_in = ST_OK;
                  freed_in      = freed_ff + ADDR_W'(1);
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - CNT_W'(1);
                  end
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_in_use_in = in_use_ff;
               rsp_peak_in   = peak_ff;
               rsp_alloc_in  = alloc_ff;
               rsp_freed_in  = freed_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RESET;
         bs_ff        <= BSIZE_RESET;
         cap_ff       <= CNT_W'(RESET_CAP);
         in_use_ff    <= '0;
         peak_ff      <= '0;
         alloc_ff     <= '0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         bs_ff        <= bs_in;
         cap_ff       <= cap_in;
         in_use_ff    <= in_use_in;
         peak_ff      <= peak_in;
         alloc_ff     <= alloc_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      offset_ff     <= offset_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_in_use_ff <= rsp_in_use_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   fba_stack #(
      .DEPTH     (DEPTH),
      .IDX_W     (IDX_W),
      .RESET_CAP (RESET_CAP)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stk_cmd),
      .push_data  (div_quo[IDX_W-1:0]),
      .refill_cap (cap_wr),
      .pop_data   (pop_data),
      .free_count (free_count)
   );

   fba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset_ff),
      .divisor  (bs_ff),
      .done     (div_done),
      .quotient (div_quo),
      .rem_zero (div_rem_zero)
   );

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_block_address   = rsp_addr_ff;
   assign rsp_blocks_in_use   = rsp_in_use_ff;
   assign rsp_highest_in_use  = rsp_peak_ff;
   assign rsp_total_allocated = rsp_alloc_ff;
   assign rsp_total_freed     = rsp_freed_ff;

endmodule

FILE: rtl/fba_stack.sv
module fba_stack
   import fba_pkg::*;
#(
   parameter int unsigned DEPTH     = 1024,
   parameter int unsigned IDX_W     = 10,
   parameter int unsigned RESET_CAP = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  stk_cmd_type      cmd,
   input  logic [IDX_W-1:0] push_data,
   input  logic [CNT_W-1:0] refill_cap,
   output logic [IDX_W-1:0] pop_data,
   output logic [CNT_W-1:0] free_count
);

   logic [IDX_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0] fc_ff, fc_in;
   logic [CNT_W-1:0] lw_ff, lw_in;
   logic [CNT_W-1:0] rd_pos;
   logic [CNT_W-1:0] rd_pos_ff;
   logic             below_ff;
   logic [IDX_W-1:0] rd_data_ff;

   // lw_ff is the lowest fill level since refill: slots below it still hold
   // their initial identity value, so their array contents are never used.
   always_comb begin
      rd_pos = fc_ff - CNT_W'(1);
      fc_in  = fc_ff;
      lw_in  = lw_ff;
      if (cmd.refill) begin
         fc_in = refill_cap;
         lw_in = refill_cap;
      end else if (cmd.pop) begin
         fc_in = rd_pos;
         if (rd_pos < lw_ff) begin
            lw_in = rd_pos;
         end
      end else if (cmd.push) begin
         fc_in = fc_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= CNT_W'(RESET_CAP);
         lw_ff <= CNT_W'(RESET_CAP);
      end else begin
         fc_ff <= fc_in;
         lw_ff <= lw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[fc_ff[IDX_W-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_pos[IDX_W-1:0]];
         rd_pos_ff  <= rd_pos;
         below_ff   <= (rd_pos < lw_ff);
      end
   end

   assign pop_data   = below_ff ? rd_pos_ff[IDX_W-1:0] : rd_data_ff;
   assign free_count = fc_ff;

endmodule

FILE: rtl/fba_div.sv
module fba_div
   import fba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ADDR_W-1:0]  dividend,
   input  logic [BSIZE_W-1:0] divisor,
   output logic               done,
   output logic [CNT_W-1:0]   quotient,
   output logic               rem_zero
);

   localparam int unsigned DSR_W  = BSIZE_W + CNT_W - 1;
   localparam int unsigned STEP_W = $clog2(CNT_W + 1);

   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // dividend < divisor * 2^CNT_W, so CNT_W quotient bits suffice.
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsr_in  = DSR_W'(divisor) << (CNT_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(CNT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= ADDR_W'(dsr_ff)) begin
            rem_in = rem_ff - ADDR_W'(dsr_ff);
            quo_in = {quo_ff[CNT_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[CNT_W-2:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fba_pkg::*;

   localparam int unsigned MAX_BLOCKS = 1024;
   localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // register groups for one layout update
   localparam logic [2:0] WR_ALL    = 3'b111;
   localparam logic [2:0] WR_LAYOUT = 3'b011;
   localparam logic [2:0] WR_CAP    = 3'b100;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_HOLDS} rx_style_type;

   typedef struct {
      logic [2:0]        status;
      logic [ADDR_W-1:0] block_address;
      logic [CNT_W-1:0]  blocks_in_use;
      logic [CNT_W-1:0]  highest_in_use;
      logic [ADDR_W-1:0] total_allocated;
      logic [ADDR_W-1:0] total_freed;
   } pool_rsp_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_BASE;
   logic [ADDR_W-1:0]    csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic                 req_mode    = MODE_ALLOC;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [2:0]           rsp_status;
   logic [ADDR_W-1:0]    rsp_block_address;
   logic [CNT_W-1:0]     rsp_blocks_in_use;
   logic [CNT_W-1:0]     rsp_highest_in_use;
   logic [ADDR_W-1:0]    rsp_total_allocated;
   logic [ADDR_W-1:0]    rsp_total_freed;

   // pool state as the block should hold it
   logic [ADDR_W-1:0]  pool_base;
   logic [BSIZE_W-1:0] pool_bsize;
   logic [CNT_W-1:0]   pool_cap;
   logic [IDX_W-1:0]   idx_stack [0:MAX_BLOCKS-1];
   logic [CNT_W-1:0]   free_depth;
   logic [CNT_W-1:0]   used_now;
   logic [CNT_W-1:0]   used_peak;
   logic [ADDR_W-1:0]  allocs_done;
   logic [ADDR_W-1:0]  frees_done;

   pool_rsp_type      awaited_responses[$];
   logic [ADDR_W-1:0] live_blocks[$];
   int                mismatch_count = 0;
   int unsigned       burst_left     = 0;

   rx_style_type rx_style      = RX_ALWAYS;
   int unsigned  rx_style_left = 0;
   int unsigned  rx_hold_left  = 0;

   fixed_block_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_block_address   (rsp_block_address),
      .rsp_blocks_in_use   (rsp_blocks_in_use),
      .rsp_highest_in_use  (rsp_highest_in_use),
      .rsp_total_allocated (rsp_total_allocated),
      .rsp_total_freed     (rsp_total_freed)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void refill_free_stack();
      for (int i = 0; i < MAX_BLOCKS; i++) idx_stack[i] = IDX_W'(i);
      free_depth = (pool_cap > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : pool_cap;
      used_now   = '0;
   endfunction

   function automatic pool_rsp_type next_pool_response(input logic mode,
                                                       input logic [ADDR_W-1:0] addr);
      pool_rsp_type      r;
      logic [ADDR_W-1:0] bs;
      logic [ADDR_W-1:0] offset;
      logic [CNT_W-1:0]  cap;
      logic [63:0]       wide;
      logic [63:0]       span;
      r.status        = ST_OK;
      r.block_address = '0;
      bs  = (pool_bsize == '0) ? ADDR_W'(1) : ADDR_W'(pool_bsize);
      cap = (pool_cap > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : pool_cap;
      if (mode == MODE_ALLOC) begin
         if (free_depth == '0) begin
            r.status = ST_EMPTY;
         end else begin
            free_depth = free_depth - CNT_W'(1);
            wide = 64'(pool_base) + 64'(idx_stack[free_depth[IDX_W-1:0]]) * 64'(bs);
            r.block_address = wide[ADDR_W-1:0];
            allocs_done = allocs_done + ADDR_W'(1);
            used_now = used_now + CNT_W'(1);
            if (used_now > used_peak) used_peak = used_now;
         end
      end else if (addr == '0) begin
         r.status = ST_NULL;
      end else begin
         // offset wraps at 32 bits, so a pool may straddle the top of memory
         offset = addr - pool_base;
         span   = 64'(bs) * 64'(cap);
         if (64'(offset) >= span || (offset % bs) != '0) begin
            r.status = ST_INVALID;
         end else if (free_depth >= cap) begin
            r.status = ST_OVERFLOW;
         end else begin
            idx_stack[free_depth[IDX_W-1:0]] = IDX_W'(offset / bs);
            free_depth = free_depth + CNT_W'(1);
            if (used_now != '0) used_now = used_now - CNT_W'(1);
            frees_done = frees_done + ADDR_W'(1);
         end
      end
      r.blocks_in_use   = used_now;
      r.highest_in_use  = used_peak;
      r.total_allocated = allocs_done;
      r.total_freed     = frees_done;
      return r;
   endfunction

   task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr);
      pool_rsp_type r;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
      r = next_pool_response(mode, addr);
      awaited_responses.push_back(r);
      if (mode == MODE_ALLOC && r.status == ST_OK) live_blocks.push_back(r.block_address);
   endtask

   // drop valid and hold until every response is in
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_responses.size() != 0);
   endtask

   task automatic set_layout(input logic [2:0] which, input logic [ADDR_W-1:0] base_word,
                             input logic [ADDR_W-1:0] bsize_word,
                             input logic [ADDR_W-1:0] cap_word);
      wait_for_drain();
      if (which[CSR_BASE]) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_BASE;
         csr_wr_data <= base_word;
         @(posedge clock);
         pool_base = base_word;
      end
      if (which[CSR_BSIZE]) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_BSIZE;
         csr_wr_data <= bsize_word;
         @(posedge clock);
         pool_bsize = bsize_word[BSIZE_W-1:0];
      end
      if (which[CSR_CAP]) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_CAP;
         csr_wr_data <= cap_word;
         @(posedge clock);
         pool_cap = cap_word[CNT_W-1:0];
         refill_free_stack();
         live_blocks.delete();
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(7))
            0, 1: gap = 0;
            2: begin
               gap = 0;
               wait_for_drain();
            end
            default: gap = $urandom_range(1, 20);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic run_traffic(input int n_items, input int alloc_pct);
      logic              mode;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] bs;
      int unsigned       cap;
      int unsigned       kind;
      int unsigned       pick;
      for (int n = 0; n < n_items; n++) begin
         bs  = (pool_bsize == '0) ? ADDR_W'(1) : ADDR_W'(pool_bsize);
         cap = (pool_cap > MAX_BLOCKS) ? MAX_BLOCKS : 32'(pool_cap);
         mode = MODE_FREE;
         kind = $urandom_range(99);
         if (kind < alloc_pct) begin
            mode = MODE_ALLOC;
            addr = $urandom;
         end else begin
            kind = $urandom_range(99);
            if (kind < 55 && live_blocks.size() != 0) begin
               pick = $urandom_range(live_blocks.size() - 1);
               addr = live_blocks[pick];
               live_blocks.delete(pick);
            end else if (kind < 70) begin
               // on a block boundary, may be one past the end
               addr = pool_base + $urandom_range(cap) * bs;
            end else if (kind < 78) begin
               addr = '0;
            end else if (kind < 88) begin
               addr = pool_base + $urandom_range(cap) * bs + $urandom_range(bs - 1);
            end else if (kind < 94) begin
               addr = pool_base - $urandom_range(1, 4 * bs);
            end else begin
               addr = $urandom;
            end
         end
         pace_sender();
         send_request(mode, addr);
      end
   endtask

   task automatic test_directed();
      // reset layout: top of stack, null, double free, misfits
      send_request(MODE_ALLOC, 32'hFFFF_FFFF);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, '0);
      send_request(MODE_FREE, BASE_RESET + 1023 * BSIZE_RESET);
      send_request(MODE_FREE, BASE_RESET + 1023 * BSIZE_RESET);
      send_request(MODE_FREE, BASE_RESET + BSIZE_RESET + 1);
      send_request(MODE_FREE, BASE_RESET - 1);
      send_request(MODE_FREE, BASE_RESET + 1024 * BSIZE_RESET);
      send_request(MODE_FREE, 32'hFFFF_FFFF);
      // zero block size acts as one; second block wraps to address zero
      set_layout(WR_ALL, 32'hFFFF_FFFF, '0, 32'd2);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, '0);
      send_request(MODE_FREE, 32'hFFFF_FFFF);
      send_request(MODE_FREE, 32'h1);
      set_layout(WR_CAP, '0, '0, '0);
      send_request(MODE_ALLOC, '0);
      send_request(MODE_FREE, 32'hFFFF_FFFF);
      // oversized capacity saturates; widest block size
      set_layout(WR_ALL, 32'h1, 32'h1_FFFF, 32'd2047);
      send_request(MODE_ALLOC, 32'h5555_5555);
      send_request(MODE_FREE, 1 + 1023 * 32'h1_FFFF);
      send_request(MODE_FREE, 1 + 1024 * 32'h1_FFFF);
      send_request(MODE_ALLOC, 32'hAAAA_AAAA);
      send_request(MODE_FREE, 1 + 7 * 32'h1_FFFF);
      send_request(MODE_ALLOC, '0);
   endtask

   task automatic test_reset_layout();
      set_layout(WR_ALL, BASE_RESET, BSIZE_RESET, CAP_RESET);
      run_traffic(200, 55);
   endtask

   task automatic test_small_pools();
      for (int p = 0; p < 8; p++) begin
         set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), $urandom_range(1, 256),
                    $urandom_range(0, 8));
         run_traffic(40, 50);
      end
   endtask

   task automatic test_wrapping_pool();
      logic [ADDR_W-1:0] bs;
      int unsigned       cap;
      for (int p = 0; p < 4; p++) begin
         bs  = $urandom_range(1, 4096);
         cap = $urandom_range(1, 64);
         set_layout(WR_ALL, 32'h0 - $urandom_range(1, cap) * bs, bs, cap);
         run_traffic(40, 50);
      end
   endtask

   task automatic test_odd_sizes();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), '0, 32'd2047);
            1: set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), 32'd65536, 32'd1025);
            2: set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), 32'h1_FFFF, 32'd1024);
            default: set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), $urandom, $urandom);
         endcase
         run_traffic(40, 50);
      end
   endtask

   // blocks handed out under one layout come back under another
   task automatic test_layout_change();
      logic [ADDR_W-1:0] bs;
      for (int p = 0; p < 3; p++) begin
         bs = $urandom_range(1, 512);
         set_layout(WR_ALL, $urandom_range(32'h7FFF_FFFF, 1), bs, $urandom_range(4, 16));
         run_traffic(20, 80);
         if (p == 0) set_layout(WR_LAYOUT, pool_base + bs, bs, '0);
         else set_layout(WR_LAYOUT, pool_base, $urandom_range(1, 512), '0);
         run_traffic(20, 20);
      end
   endtask

   task automatic test_random_layouts();
      for (int p = 0; p < 6; p++) begin
         set_layout(WR_ALL, $urandom_range(32'hFFFF_FFFF, 1), $urandom_range(1, 65536),
                    $urandom_range(0, 1024));
         run_traffic(30, $urandom_range(30, 80));
      end
   endtask

   initial begin
      pool_base   = BASE_RESET;
      pool_bsize  = BSIZE_RESET;
      pool_cap    = CAP_RESET;
      used_peak   = '0;
      allocs_done = '0;
      frees_done  = '0;
      refill_free_stack();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_reset_layout();
      test_small_pools();
      test_wrapping_pool();
      test_odd_sizes();
      test_layout_change();
      test_random_layouts();
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // receiver stall pattern; the style is picked at random and switched when its countdown runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_style_left == 0) begin
            rx_style      <= rx_style_type'($urandom_range(3));
            rx_style_left <= $urandom_range(50, 300);
         end else begin
            rx_style_left <= rx_style_left - 1;
         end
         case (rx_style)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= $urandom_range(1);
            RX_SPARSE: rsp_ready <= ($urandom_range(3) == 0);
            default: begin
               if (rx_hold_left != 0) begin
                  rsp_ready    <= 1'b0;
                  rx_hold_left <= rx_hold_left - 1;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(7) == 0) rx_hold_left <= $urandom_range(5, 30);
               end
            end
         endcase
      end
   end

   task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $error("response beat with nothing awaited");
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_status));
            check_field("block_address", want.block_address, rsp_block_address);
            check_field("blocks_in_use", ADDR_W'(want.blocks_in_use),
                        ADDR_W'(rsp_blocks_in_use));
            check_field("highest_in_use", ADDR_W'(want.highest_in_use),
                        ADDR_W'(rsp_highest_in_use));
            check_field("total_allocated", want.total_allocated, rsp_total_allocated);
            check_field("total_freed", want.total_freed, rsp_total_freed);
         end
      end
   end

endmodule
